// File: rtl/a2s_pkg.sv
// Shared types and constants for the atan2 series angle block.
// No dependencies; every other file refers to this package by scoped names.
package a2s_pkg;

  localparam int CFG_W    = 7;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_TERM_COUNT = '0;
  localparam logic [CFG_W-1:0] TERM_COUNT_RESET = 7'd32;

  localparam int Q_W     = 32;
  localparam int Q_FRAC  = 31;
  localparam int QD_W    = 33;
  localparam int PROD_W  = 64;
  localparam int COEF_W  = 55;
  localparam int ACC_W   = 56;
  localparam int MAG_W   = 56;
  localparam int ANGLE_W = 32;
  localparam int SD_STEP = 8;

  localparam logic [QD_W-1:0]   ONE_Q31     = 33'h0_8000_0000;
  localparam logic [COEF_W-1:0] ONE_Q54     = 55'h40_0000_0000_0000;
  localparam logic [MAG_W-1:0]  PI_Q54      = 56'hC9_0FDA_A221_68C2;
  localparam logic [MAG_W-1:0]  HALF_PI_Q54 = 56'h64_87ED_5110_B461;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MAG,
    ST_ORDER,
    ST_RATIO,
    ST_SQ_MUL,
    ST_SQ_WR,
    ST_ZDIV_GO,
    ST_ZDIV,
    ST_PDIV_GO,
    ST_PDIV,
    ST_TERM_HI,
    ST_TERM_LO,
    ST_TERM_ADD,
    ST_TERM_GO,
    ST_TERM_DIV,
    ST_TERM_SUM,
    ST_FIN_HI,
    ST_FIN_LO,
    ST_FIN_ADD,
    ST_QUAD_REF,
    ST_QUAD_FIX,
    ST_ROUND,
    ST_SIGN,
    ST_DONE
  } a2s_state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } a2s_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } a2s_stat_t;

endpackage

// File: rtl/a2s_if.sv
// Valid/ready channel interfaces for coordinate beats and angle beats.
// Depends on a2s_pkg for the angle width.
interface a2s_coord_if #(
  parameter int INPUT_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [INPUT_WIDTH-1:0] x_coord;
  logic signed [INPUT_WIDTH-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

interface a2s_angle_if;
  logic                                valid;
  logic                                ready;
  logic signed [a2s_pkg::ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

// File: rtl/a2s_qdiv.sv
// Bit-serial divider: floor(num * 2^31 / den) for num <= den, one quotient bit a cycle.
// Depends on a2s_pkg for operand widths.
module a2s_qdiv (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [a2s_pkg::QD_W-1:0]  num,
  input  logic [a2s_pkg::QD_W-1:0]  den,
  output logic                      done,
  output logic [a2s_pkg::Q_W-1:0]   quot
);

  localparam int CNT_W = $clog2(a2s_pkg::Q_W);
  localparam int REM_W = a2s_pkg::QD_W + 1;

  logic                     busy;
  logic [CNT_W-1:0]         cnt;
  logic [REM_W-1:0]         rem;
  logic [REM_W-1:0]         trial;
  logic [REM_W-1:0]         rem_next;
  logic [a2s_pkg::QD_W-1:0] dvsr;
  logic                     ge;

  always_comb begin
    trial    = (cnt == '0) ? rem : {rem[REM_W-2:0], 1'b0};
    ge       = trial >= {1'b0, dvsr};
    rem_next = ge ? trial - {1'b0, dvsr} : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(a2s_pkg::Q_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num};
      dvsr <= den;
      cnt  <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= {quot[a2s_pkg::Q_W-2:0], ge};
      cnt  <= cnt + CNT_W'(1);
    end
  end

endmodule

// File: rtl/a2s_sdiv.sv
// Short-divisor divider: quotient and nonzero-remainder flag of a coefficient
// by a small odd divisor, eight quotient bits a cycle. Depends on a2s_pkg.
module a2s_sdiv #(
  parameter int DIV_W = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [a2s_pkg::COEF_W-1:0]  num,
  input  logic [DIV_W-1:0]            dvsr_in,
  output logic                        done,
  output logic [a2s_pkg::COEF_W-1:0]  quot,
  output logic                        rem_nz
);

  localparam int DIGITS = (a2s_pkg::COEF_W + a2s_pkg::SD_STEP - 1) / a2s_pkg::SD_STEP;
  localparam int PAD_W  = DIGITS * a2s_pkg::SD_STEP;
  localparam int CNT_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [PAD_W-1:0] work;
  logic [PAD_W-1:0] work_next;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] rem_next;
  logic [DIV_W:0]   r_w;
  logic [DIV_W-1:0] dvsr;

  always_comb begin
    rem_next  = rem;
    work_next = work;
    r_w       = '0;
    for (int i = 0; i < a2s_pkg::SD_STEP; i++) begin
      r_w = {rem_next, work_next[PAD_W-1]};
      if (r_w >= {1'b0, dvsr}) begin
        r_w       = r_w - {1'b0, dvsr};
        work_next = {work_next[PAD_W-2:0], 1'b1};
      end else begin
        work_next = {work_next[PAD_W-2:0], 1'b0};
      end
      rem_next = r_w[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(DIGITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= PAD_W'(num);
      rem  <= '0;
      dvsr <= dvsr_in;
      cnt  <= '0;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
      cnt  <= cnt + CNT_W'(1);
    end
  end

  assign quot   = work[a2s_pkg::COEF_W-1:0];
  assign rem_nz = rem != '0;

endmodule

// File: rtl/a2s_core.sv
// Sequencer and datapath: ratio, series terms and quadrant fix-up on one shared
// multiplier and two iterative dividers. Depends on a2s_pkg, a2s_qdiv, a2s_sdiv.
module a2s_core #(
  parameter int INPUT_WIDTH = 32,
  parameter int FRAC_BITS   = 29,
  parameter int MAX_TERMS   = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  a2s_pkg::a2s_ctrl_t                ctrl,
  input  logic [INPUT_WIDTH-1:0]            x_coord,
  input  logic [INPUT_WIDTH-1:0]            y_coord,
  input  logic [a2s_pkg::CFG_W-1:0]         term_count,
  output a2s_pkg::a2s_stat_t                stat,
  output logic [a2s_pkg::ANGLE_W-1:0]       angle
);

  localparam int LW    = $clog2(MAX_TERMS + 1);
  localparam int CW    = (LW > a2s_pkg::CFG_W) ? LW : a2s_pkg::CFG_W;
  localparam int SH    = 54 - FRAC_BITS;
  localparam logic [a2s_pkg::MAG_W-1:0] RND = a2s_pkg::MAG_W'(1) << (SH - 1);

  a2s_pkg::a2s_state_t state;
  a2s_pkg::a2s_state_t state_next;

  logic [INPUT_WIDTH-1:0]          x_raw;
  logic [INPUT_WIDTH-1:0]          y_raw;
  logic [INPUT_WIDTH-1:0]          ax;
  logic [INPUT_WIDTH-1:0]          ay;
  logic                            xneg;
  logic                            yneg;
  logic                            swap;
  logic                            swap_c;
  logic [a2s_pkg::Q_W-1:0]         v;
  logic [a2s_pkg::Q_W-1:0]         v2;
  logic [a2s_pkg::Q_W-1:0]         zf;
  logic [a2s_pkg::Q_W-1:0]         pf;
  logic [a2s_pkg::QD_W-1:0]        den_c;
  logic [a2s_pkg::COEF_W-1:0]      coef;
  logic [a2s_pkg::ACC_W-1:0]       acc;
  logic [a2s_pkg::PROD_W-1:0]      hold;
  logic [a2s_pkg::PROD_W-1:0]      prod;
  logic [a2s_pkg::Q_W-1:0]         mul_a;
  logic [a2s_pkg::Q_W-1:0]         mul_b;
  logic [a2s_pkg::MAG_W-1:0]       theta;
  logic [LW-1:0]                   k;
  logic [LW-1:0]                   limit;
  logic [LW-1:0]                   limit_c;
  logic [CW-1:0]                   tc_ext;

  logic                            qd_start;
  logic [a2s_pkg::QD_W-1:0]        qd_num;
  logic [a2s_pkg::QD_W-1:0]        qd_den;
  logic                            qd_done;
  logic [a2s_pkg::Q_W-1:0]         qd_quot;

  logic                            sd_start;
  logic                            sd_done;
  logic [a2s_pkg::COEF_W-1:0]      sd_quot;
  logic                            sd_nz;

  assign tc_ext  = CW'(term_count);
  assign limit_c = (tc_ext > CW'(MAX_TERMS)) ? LW'(MAX_TERMS) : LW'(term_count);
  assign swap_c  = ay > ax;
  assign den_c   = a2s_pkg::ONE_Q31 + a2s_pkg::QD_W'(v2);

  a2s_qdiv u_qdiv (
    .clk   (clk),
    .rst   (rst),
    .start (qd_start),
    .num   (qd_num),
    .den   (qd_den),
    .done  (qd_done),
    .quot  (qd_quot)
  );

  a2s_sdiv #(
    .DIV_W (LW + 1)
  ) u_sdiv (
    .clk     (clk),
    .rst     (rst),
    .start   (sd_start),
    .num     (coef),
    .dvsr_in ({k, 1'b1}),
    .done    (sd_done),
    .quot    (sd_quot),
    .rem_nz  (sd_nz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= a2s_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      a2s_pkg::ST_IDLE:     if (ctrl.start) state_next = a2s_pkg::ST_MAG;
      a2s_pkg::ST_MAG:      state_next = a2s_pkg::ST_ORDER;
      a2s_pkg::ST_ORDER:    state_next = a2s_pkg::ST_RATIO;
      a2s_pkg::ST_RATIO:    if (qd_done) state_next = a2s_pkg::ST_SQ_MUL;
      a2s_pkg::ST_SQ_MUL:   state_next = a2s_pkg::ST_SQ_WR;
      a2s_pkg::ST_SQ_WR:    state_next = a2s_pkg::ST_ZDIV_GO;
      a2s_pkg::ST_ZDIV_GO:  state_next = a2s_pkg::ST_ZDIV;
      a2s_pkg::ST_ZDIV:     if (qd_done) state_next = a2s_pkg::ST_PDIV_GO;
      a2s_pkg::ST_PDIV_GO:  state_next = a2s_pkg::ST_PDIV;
      a2s_pkg::ST_PDIV: begin
        if (qd_done) begin
          state_next = (limit == '0) ? a2s_pkg::ST_FIN_HI : a2s_pkg::ST_TERM_HI;
        end
      end
      a2s_pkg::ST_TERM_HI:  state_next = a2s_pkg::ST_TERM_LO;
      a2s_pkg::ST_TERM_LO:  state_next = a2s_pkg::ST_TERM_ADD;
      a2s_pkg::ST_TERM_ADD: state_next = a2s_pkg::ST_TERM_GO;
      a2s_pkg::ST_TERM_GO:  state_next = a2s_pkg::ST_TERM_DIV;
      a2s_pkg::ST_TERM_DIV: if (sd_done) state_next = a2s_pkg::ST_TERM_SUM;
      a2s_pkg::ST_TERM_SUM: begin
        state_next = (k == limit) ? a2s_pkg::ST_FIN_HI : a2s_pkg::ST_TERM_HI;
      end
      a2s_pkg::ST_FIN_HI:   state_next = a2s_pkg::ST_FIN_LO;
      a2s_pkg::ST_FIN_LO:   state_next = a2s_pkg::ST_FIN_ADD;
      a2s_pkg::ST_FIN_ADD:  state_next = a2s_pkg::ST_QUAD_REF;
      a2s_pkg::ST_QUAD_REF: state_next = a2s_pkg::ST_QUAD_FIX;
      a2s_pkg::ST_QUAD_FIX: state_next = a2s_pkg::ST_ROUND;
      a2s_pkg::ST_ROUND:    state_next = a2s_pkg::ST_SIGN;
      a2s_pkg::ST_SIGN:     state_next = a2s_pkg::ST_DONE;
      a2s_pkg::ST_DONE:     if (ctrl.ack) state_next = a2s_pkg::ST_IDLE;
      default:              state_next = a2s_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    qd_start  = 1'b0;
    qd_num    = a2s_pkg::QD_W'(v);
    qd_den    = den_c;
    sd_start  = 1'b0;
    mul_a     = v;
    mul_b     = v;
    stat.idle = state == a2s_pkg::ST_IDLE;
    stat.done = state == a2s_pkg::ST_DONE;
    unique case (state)
      a2s_pkg::ST_ORDER: begin
        qd_start = 1'b1;
        qd_num   = a2s_pkg::QD_W'(swap_c ? ax : ay);
        qd_den   = a2s_pkg::QD_W'(swap_c ? ay : ax);
      end
      a2s_pkg::ST_ZDIV_GO: begin
        qd_start = 1'b1;
        qd_num   = a2s_pkg::QD_W'(v2);
      end
      a2s_pkg::ST_PDIV_GO: begin
        qd_start = 1'b1;
      end
      a2s_pkg::ST_TERM_HI: begin
        mul_a = a2s_pkg::Q_W'(coef[a2s_pkg::COEF_W-1:a2s_pkg::Q_FRAC]);
        mul_b = zf;
      end
      a2s_pkg::ST_TERM_LO: begin
        mul_a = a2s_pkg::Q_W'(coef[a2s_pkg::Q_FRAC-1:0]);
        mul_b = zf;
      end
      a2s_pkg::ST_TERM_GO: begin
        sd_start = 1'b1;
      end
      a2s_pkg::ST_FIN_HI: begin
        mul_a = a2s_pkg::Q_W'(acc[a2s_pkg::ACC_W-1:a2s_pkg::Q_FRAC]);
        mul_b = pf;
      end
      a2s_pkg::ST_FIN_LO: begin
        mul_a = a2s_pkg::Q_W'(acc[a2s_pkg::Q_FRAC-1:0]);
        mul_b = pf;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= a2s_pkg::PROD_W'(mul_a) * a2s_pkg::PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    case (state)
      a2s_pkg::ST_IDLE: begin
        if (ctrl.start) begin
          x_raw <= x_coord;
          y_raw <= y_coord;
          limit <= limit_c;
        end
      end
      a2s_pkg::ST_MAG: begin
        xneg <= x_raw[INPUT_WIDTH-1];
        yneg <= y_raw[INPUT_WIDTH-1];
        ax   <= x_raw[INPUT_WIDTH-1] ? '0 - x_raw : x_raw;
        ay   <= y_raw[INPUT_WIDTH-1] ? '0 - y_raw : y_raw;
      end
      a2s_pkg::ST_ORDER:   swap <= swap_c;
      a2s_pkg::ST_RATIO:   if (qd_done) v <= qd_quot;
      a2s_pkg::ST_SQ_WR:   v2 <= a2s_pkg::Q_W'(prod >> a2s_pkg::Q_FRAC);
      a2s_pkg::ST_ZDIV:    if (qd_done) zf <= qd_quot;
      a2s_pkg::ST_PDIV: begin
        if (qd_done) begin
          pf   <= qd_quot;
          coef <= a2s_pkg::ONE_Q54;
          acc  <= a2s_pkg::ACC_W'(a2s_pkg::ONE_Q54);
          k    <= LW'(1);
        end
      end
      a2s_pkg::ST_TERM_LO:  hold <= prod;
      a2s_pkg::ST_TERM_ADD: coef <= a2s_pkg::COEF_W'(hold + (prod >> a2s_pkg::Q_FRAC));
      a2s_pkg::ST_TERM_DIV: begin
        if (sd_done) coef <= coef - sd_quot - a2s_pkg::COEF_W'(sd_nz);
      end
      a2s_pkg::ST_TERM_SUM: begin
        acc <= acc + a2s_pkg::ACC_W'(coef);
        if (k != limit) k <= k + LW'(1);
      end
      a2s_pkg::ST_FIN_LO:   hold <= prod;
      a2s_pkg::ST_FIN_ADD:  theta <= a2s_pkg::MAG_W'(hold + (prod >> a2s_pkg::Q_FRAC));
      a2s_pkg::ST_QUAD_REF: if (swap) theta <= a2s_pkg::HALF_PI_Q54 - theta;
      a2s_pkg::ST_QUAD_FIX: begin
        if (ax == '0) begin
          theta <= (ay == '0) ? '0 : a2s_pkg::HALF_PI_Q54;
        end else if (xneg) begin
          theta <= a2s_pkg::PI_Q54 - theta;
        end
      end
      a2s_pkg::ST_ROUND:    theta <= (theta + RND) >> SH;
      a2s_pkg::ST_SIGN: begin
        angle <= yneg ? a2s_pkg::ANGLE_W'(0) - theta[a2s_pkg::ANGLE_W-1:0]
                      : theta[a2s_pkg::ANGLE_W-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/atan2_series_angle.sv
// Top level of the atan2 series angle block: APB register, channels, result register.
// Depends on a2s_pkg, a2s_if (a2s_coord_if, a2s_angle_if) and a2s_core.
//
// Usage: a coordinate beat (x_coord, y_coord, signed) enters on coord; one angle
// beat leaves on result: atan2(y, x) in radians, two's complement with FRAC_BITS
// fraction bits. Register term_count (APB byte address 0, reset 32) sets how
// many series terms follow the first; values above MAX_TERMS are clamped.
// Each beat runs through three ratio divisions (32 quotient bits each) and then,
// per series term, a multiply and a digit divide. One item is in flight at a
// time: coord.ready is high only while the sequencer is idle, so a new beat is
// taken only once the sequencer has handed off the previous angle.
// The result register lets the sequencer hand off a finished angle and take the
// next beat while the receiver still holds an earlier angle; a finished angle
// waits in the sequencer while result is stalled with a full register.
// Reset (rst, synchronous) empties the result register, idles the sequencer and
// sets term_count to 32. Write term_count only while no beat is in flight.
module atan2_series_angle #(
  parameter int INPUT_WIDTH = 32,
  parameter int FRAC_BITS   = 29,
  parameter int MAX_TERMS   = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [a2s_pkg::PADDR_W-1:0]   paddr,
  input  logic [a2s_pkg::PDATA_W-1:0]   pwdata,
  output logic [a2s_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  a2s_coord_if.sink                     coord,
  a2s_angle_if.source                   result
);

  logic [a2s_pkg::CFG_W-1:0]   term_count;
  logic                        reg_sel;
  a2s_pkg::a2s_ctrl_t          core_ctrl;
  a2s_pkg::a2s_stat_t          core_stat;
  logic [a2s_pkg::ANGLE_W-1:0] core_angle;
  logic                        out_valid;
  logic [a2s_pkg::ANGLE_W-1:0] angle_q;

  assign reg_sel = paddr[a2s_pkg::PADDR_W-1:2] == a2s_pkg::REG_TERM_COUNT;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? a2s_pkg::PDATA_W'(term_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= a2s_pkg::TERM_COUNT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      term_count <= pwdata[a2s_pkg::CFG_W-1:0];
    end
  end

  assign coord.ready     = core_stat.idle;
  assign core_ctrl.start = coord.valid && core_stat.idle;
  assign core_ctrl.ack   = core_stat.done && (!out_valid || result.ready);

  a2s_core #(
    .INPUT_WIDTH (INPUT_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .MAX_TERMS   (MAX_TERMS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (core_ctrl),
    .x_coord    (coord.x_coord),
    .y_coord    (coord.y_coord),
    .term_count (term_count),
    .stat       (core_stat),
    .angle      (core_angle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_ctrl.ack) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_ctrl.ack) angle_q <= core_angle;
  end

  assign result.valid = out_valid;
  assign result.angle = angle_q;

  localparam int SH = 54 - FRAC_BITS;
  localparam logic [a2s_pkg::MAG_W-1:0] MAX_MAG =
    (a2s_pkg::PI_Q54 + (a2s_pkg::MAG_W'(1) << (SH - 1))) >> SH;
  localparam logic signed [a2s_pkg::ANGLE_W-1:0] ANGLE_MAX = a2s_pkg::ANGLE_W'(MAX_MAG);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    coord.valid && coord.ready |=> !core_stat.idle)
    else $error("sequencer idle right after a coordinate beat");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    core_ctrl.ack |=> !core_stat.done)
    else $error("sequencer still done after hand-off");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    core_ctrl.ack |=> result.valid && result.angle == $past(core_angle))
    else $error("result register missed a hand-off");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ($signed(result.angle) <= ANGLE_MAX) &&
                     ($signed(result.angle) >= -ANGLE_MAX))
    else $error("angle outside plus or minus pi");

endmodule

// File: tb/sv/atan2_series_angle_check.sv
// Scoreboard for the atan2 series angle block: tracks term_count from APB traffic,
// predicts each angle from accepted coordinate beats and compares result beats.
// Depends on a2s_pkg and the a2s_coord_if / a2s_angle_if channel interfaces.
module atan2_series_angle_check #(
  parameter int INPUT_WIDTH = 32,
  parameter int FRAC_BITS   = 29,
  parameter int MAX_TERMS   = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [a2s_pkg::PADDR_W-1:0]   paddr,
  input  logic [a2s_pkg::PDATA_W-1:0]   pwdata,
  input  logic [a2s_pkg::PDATA_W-1:0]   prdata,
  input  logic                          pready,
  a2s_coord_if                          coord,
  a2s_angle_if                          result,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROUND_SH = 54 - FRAC_BITS;
  localparam logic [63:0] PI_MAG   = 64'(a2s_pkg::PI_Q54);
  localparam logic [63:0] HALF_PI  = 64'(a2s_pkg::HALF_PI_Q54);
  localparam logic [63:0] UNIT_Q54 = 64'(a2s_pkg::ONE_Q54);

  logic [a2s_pkg::CFG_W-1:0]   term_limit;
  logic [a2s_pkg::ANGLE_W-1:0] want_angle;
  logic [a2s_pkg::ANGLE_W-1:0] angle_queue[$];

  function automatic logic [63:0] scale_q31(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] upper;
    logic [63:0] lower;
    upper = a >> 31;
    lower = a & 64'h7FFF_FFFF;
    return upper * b + ((lower * b) >> 31);
  endfunction

  function automatic logic [63:0] atan_q54(input logic [63:0] lo_mag,
                                           input logic [63:0] hi_mag,
                                           input logic [a2s_pkg::CFG_W-1:0] terms);
    logic [63:0] ratio, ratio_sq, denom, zf, pf, coef, acc, two_k;
    int          n_terms;
    ratio    = (lo_mag << 31) / hi_mag;
    ratio_sq = (ratio * ratio) >> 31;
    denom    = (64'd1 << 31) + ratio_sq;
    zf       = (ratio_sq << 31) / denom;
    pf       = (ratio << 31) / denom;
    n_terms  = (int'(terms) > MAX_TERMS) ? MAX_TERMS : int'(terms);
    coef     = UNIT_Q54;
    acc      = UNIT_Q54;
    for (int k = 1; k <= n_terms; k++) begin
      two_k = 64'(2 * k);
      coef  = scale_q31(coef, zf);
      coef  = (coef * two_k) / (two_k + 64'd1);
      acc   = acc + coef;
    end
    return scale_q31(acc, pf);
  endfunction

  function automatic logic [63:0] coord_mag(input logic [INPUT_WIDTH-1:0] raw);
    logic [63:0] ext;
    ext = 64'(raw);
    return raw[INPUT_WIDTH-1] ? ((64'd1 << INPUT_WIDTH) - ext) : ext;
  endfunction

  function automatic logic [a2s_pkg::ANGLE_W-1:0] predict_angle(
    input logic [INPUT_WIDTH-1:0]    x,
    input logic [INPUT_WIDTH-1:0]    y,
    input logic [a2s_pkg::CFG_W-1:0] terms
  );
    logic [63:0] ax, ay, theta, mag;
    logic        neg;
    ax    = coord_mag(x);
    ay    = coord_mag(y);
    theta = '0;
    if (ax != 0 || ay != 0) begin
      if (ay <= ax) begin
        theta = atan_q54(ay, ax, terms);
      end else begin
        theta = HALF_PI - atan_q54(ax, ay, terms);
      end
    end
    if (ax == 0) begin
      mag = (ay == 0) ? 64'd0 : HALF_PI;
      neg = y[INPUT_WIDTH-1] && ay != 0;
    end else if (!x[INPUT_WIDTH-1]) begin
      mag = theta;
      neg = y[INPUT_WIDTH-1];
    end else begin
      mag = PI_MAG - theta;
      neg = y[INPUT_WIDTH-1];
    end
    mag = (mag + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
    return neg ? a2s_pkg::ANGLE_W'(64'd0 - mag) : mag[a2s_pkg::ANGLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      term_limit = a2s_pkg::TERM_COUNT_RESET;
      fail_count = 0;
      angle_queue.delete();
    end else begin
      if (psel && penable && pready &&
          paddr[a2s_pkg::PADDR_W-1:2] == a2s_pkg::REG_TERM_COUNT) begin
        if (pwrite) begin
          term_limit = pwdata[a2s_pkg::CFG_W-1:0];
        end else if (prdata !== a2s_pkg::PDATA_W'(term_limit)) begin
          $error("term_count: expected %0d, actual %0d", term_limit, prdata);
          fail_count++;
        end
      end
      if (coord.valid && coord.ready) begin
        angle_queue.push_back(predict_angle(coord.x_coord, coord.y_coord, term_limit));
      end
      if (result.valid && result.ready) begin
        if (angle_queue.size() == 0) begin
          $error("angle: expected none, actual %0d", $signed(result.angle));
          fail_count++;
        end else begin
          want_angle = angle_queue.pop_front();
          if (result.angle !== want_angle) begin
            $error("angle: expected %0d, actual %0d", $signed(want_angle),
                   $signed(result.angle));
            fail_count++;
          end
        end
      end
    end
    pending = angle_queue.size();
  end

endmodule

// File: tb/sv/atan2_series_angle_test.sv
// Top of the atan2 series angle testbench: clock, reset, APB setup and coordinate
// stimulus with random sender gaps and receiver stalls. Uses atan2_series_angle_check.
// Depends on a2s_pkg, a2s_if and the atan2_series_angle RTL.
module atan2_series_angle_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 1200;
  localparam logic [a2s_pkg::REG_IDX_W-1:0] REG_UNMAPPED = 1'b1;
  localparam logic [31:0] COORD_MIN = 32'h8000_0000;
  localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [a2s_pkg::PADDR_W-1:0] paddr;
  logic [a2s_pkg::PDATA_W-1:0] pwdata;
  logic [a2s_pkg::PDATA_W-1:0] prdata;
  logic                        pready;
  int                          fail_count;
  int                          pending;
  int                          cycle_count;
  int                          burst_left;
  int                          hold_left;
  int                          stall_mode;

  a2s_coord_if coord_ch ();
  a2s_angle_if angle_ch ();

  atan2_series_angle uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coord   (coord_ch),
    .result  (angle_ch)
  );

  atan2_series_angle_check angle_check (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .coord      (coord_ch),
    .result     (angle_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  task automatic apb_access(input logic wr, input logic [a2s_pkg::REG_IDX_W-1:0] idx,
                            input logic [a2s_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_terms(input logic [a2s_pkg::CFG_W-1:0] terms);
    apb_access(1'b1, a2s_pkg::REG_TERM_COUNT, {25'($urandom()), terms});
    apb_access(1'b1, REG_UNMAPPED, $urandom());
    apb_access(1'b0, a2s_pkg::REG_TERM_COUNT, '0);
  endtask

  task automatic send_coord(input logic [31:0] x, input logic [31:0] y);
    int gap;
    coord_ch.valid   <= 1'b1;
    coord_ch.x_coord <= x;
    coord_ch.y_coord <= y;
    do @(posedge clk); while (!coord_ch.ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        coord_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic drain_angles();
    coord_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    logic [31:0] tmp;
    case ($urandom_range(0, 11)) inside
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3, 4: return 32'($urandom_range(0, 64)) - 32'd32;
      5, 6: begin
        tmp = $urandom() >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -tmp : tmp;
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic run_coords(input int n_items);
    logic [31:0] x, y;
    for (int i = 0; i < n_items; i++) begin
      x = pick_coord();
      y = pick_coord();
      case ($urandom_range(0, 9))
        0: y = x;
        1: y = -x;
        2: y = x + 32'd1;
        3: y = x - 32'd1;
        default: ;
      endcase
      send_coord(x, y);
    end
    drain_angles();
  endtask

  initial begin
    angle_ch.ready = 1'b0;
    hold_left      = 0;
    stall_mode     = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        hold_left  = (stall_mode == 1) ? $urandom_range(1, 400) : $urandom_range(1, 60);
      end
      hold_left--;
      case (stall_mode)
        0: angle_ch.ready <= 1'b0;
        1: angle_ch.ready <= 1'b1;
        default: angle_ch.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    coord_ch.valid   = 1'b0;
    coord_ch.x_coord = '0;
    coord_ch.y_coord = '0;
    burst_left       = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset value of term_count, then the quadrant and axis corners
    apb_access(1'b0, a2s_pkg::REG_TERM_COUNT, '0);
    send_coord(32'd0, 32'd0);
    send_coord(32'd0, 32'd5);
    send_coord(32'd0, -32'sd5);
    send_coord(32'd5, 32'd0);
    send_coord(-32'sd5, 32'd0);
    send_coord(COORD_MAX, 32'd0);
    send_coord(COORD_MIN, 32'd0);
    send_coord(32'd0, COORD_MIN);
    send_coord(32'd0, COORD_MAX);
    send_coord(COORD_MIN, COORD_MIN);
    send_coord(COORD_MAX, COORD_MAX);
    send_coord(COORD_MIN, COORD_MAX);
    send_coord(COORD_MAX, COORD_MIN);
    send_coord(32'd1, COORD_MAX);
    send_coord(COORD_MAX, 32'd1);
    send_coord(COORD_MIN, -32'sd1);
    send_coord(-32'sd1, -32'sd1);
    send_coord(32'd3, 32'd4);
    send_coord(-32'sd3, 32'd4);
    send_coord(-32'sd3, -32'sd4);
    send_coord(32'd3, -32'sd4);
    send_coord(32'd1, -32'sd1);
    send_coord(-32'sd4, 32'd3);
    send_coord(32'hFFFF_FFFF, 32'h7FFF_0000);
    drain_angles();

    set_terms(7'd0);
    run_coords(60);
    set_terms(7'd1);
    run_coords(60);
    set_terms(7'd127);
    run_coords(25);
    set_terms(7'd64);
    run_coords(25);
    set_terms(7'd65);
    run_coords(20);
    repeat (8) begin
      set_terms(7'($urandom_range(2, 16)));
      run_coords(60);
    end
    set_terms(7'($urandom_range(0, 127)));
    run_coords(30);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
